>>> rtl/mta_pkg.sv
// ============================================================================
// mta_pkg
// Shared types and constants of the mesh tangent accumulator.
// ============================================================================
package mta_pkg;

    localparam int DEF_VERTEX_SLOTS = 1024;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 32;
    localparam int UV_W   = 24;
    localparam int ACC_W  = 48;
    localparam int TAN_W  = 18;
    localparam int VTX_W  = 3 * POS_W + 2 * UV_W;
    localparam int ACCW_W = 3 * ACC_W;
    localparam int DIV_W  = 64;
    localparam int SQRT_W = 64;
    localparam int MUL_W  = 34;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TRI   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_VRD_A,
        S_VRD_B,
        S_VRD_C,
        S_VRD_W,
        S_MUL,
        S_MACC,
        S_DIVW,
        S_ACC_RD,
        S_ACC_WR,
        S_RD2,
        S_MAG,
        S_NORM,
        S_SQ,
        S_SQACC,
        S_SQRTW,
        S_NDIVW,
        S_OUT
    } t_state;

endpackage

>>> rtl/mta_ram.sv
// ============================================================================
// mta_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module mta_ram #(
    parameter int W = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mta_div.sv
// ============================================================================
// mta_div
// Unsigned restoring divider, one quotient bit per cycle.
// ============================================================================
module mta_div import mta_pkg::*; #(
    parameter int W = DIV_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_den, n_den;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    always_comb begin
        trial  = {r_rem, r_quo[W-1]};
        diff   = trial - {1'b0, r_den};
        ge     = (trial >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(W);
            n_rem  = '0;
            n_quo  = i_num;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = ge ? diff[W-1:0] : trial[W-1:0];
            n_quo = {r_quo[W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> rtl/mta_sqrt.sv
// ============================================================================
// mta_sqrt
// Integer square root, digit-by-digit, one result bit per cycle.
// ============================================================================
module mta_sqrt import mta_pkg::*; #(
    parameter int W = SQRT_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_val,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [W-1:0] r_n, n_n;
    logic [W-1:0] r_res, n_res;
    logic [W-1:0] r_bit, n_bit;
    logic [W-1:0] sum;
    logic         ge;

    always_comb begin
        sum    = r_res + r_bit;
        ge     = (r_n >= sum);
        n_busy = r_busy;
        n_done = 1'b0;
        n_n    = r_n;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_n    = i_val;
            n_res  = '0;
            n_bit  = {2'b01, {(W-2){1'b0}}};
        end else if (r_busy) begin
            n_n   = ge ? (r_n - sum) : r_n;
            n_res = ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
            n_bit = r_bit >> 2;
            if (r_bit == W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[W/2-1:0];

endmodule

>>> rtl/mesh_tangent_accumulator.sv
// ============================================================================
// mesh_tangent_accumulator
// Per-vertex tangent accumulation and normalized readback for triangle meshes.
// ============================================================================
// Usage:
//  - Input channel (i_in_valid / o_in_stall) takes one item: op 0 writes a
//    vertex and clears its tangent sum, op 1 adds a triangle's tangent to its
//    three corners, op 2 reads one vertex's unit tangent. Op 3 is dropped.
//  - Output channel (o_out_valid / i_out_stall) gives one item per op 2.
//  - Op 1 is dominated by three 64-step divisions on the shared divider,
//    plus 8 products on the shared multiplier and 3 read-modify-write
//    passes on the accumulator RAM.
//  - Op 2 runs up to 29 normalizing shifts, 3 squares, a 32-step square
//    root and three 64-step divisions; a zero sum skips them.
//  - Out-of-range ops 0 and 1 are dropped; out-of-range op 2 reports zero length.
//  - After reset the accumulator RAM is zeroed, one entry a cycle, over all
//    VERTEX_SLOTS entries; o_in_stall stays high meanwhile.
//  - A finished result sits in the output register; the block takes a new
//    item while it waits, but holds the next result, and stalls its input,
//    until the receiver lifts i_out_stall.
// ============================================================================
module mesh_tangent_accumulator import mta_pkg::*; #(
    parameter int VERTEX_SLOTS = DEF_VERTEX_SLOTS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_op,
    input  logic [IDX_W-1:0]        i_vertex_index,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [UV_W-1:0]  i_tex_u,
    input  logic signed [UV_W-1:0]  i_tex_v,
    input  logic [IDX_W-1:0]        i_corner_a,
    input  logic [IDX_W-1:0]        i_corner_b,
    input  logic [IDX_W-1:0]        i_corner_c,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [IDX_W-1:0]        o_read_index,
    output logic signed [TAN_W-1:0] o_tangent_x,
    output logic signed [TAN_W-1:0] o_tangent_y,
    output logic signed [TAN_W-1:0] o_tangent_z,
    output logic                    o_zero_length
);

    localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam logic [16:0] SLOTS_W = 17'(VERTEX_SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_SLOTS - 1);
    localparam logic [DIV_W-1:0] LIM_P = DIV_W'(64'h7FFF_FFFF_FFFF);
    localparam logic [DIV_W-1:0] LIM_N = DIV_W'(64'h8000_0000_0000);

    // slot index to RAM address, zero-extended or cut to the RAM depth
    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [AW+IDX_W-1:0] w;
        w = {{AW{1'b0}}, idx};
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        logic [16:0] w;
        w = {7'd0, idx};
        return (w < SLOTS_W);
    endfunction

    // control
    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic           r_ovalid, n_ovalid;
    logic [2:0]     r_mstep, n_mstep;
    logic [1:0]     r_cj, n_cj;

    // payload
    logic [IDX_W-1:0]        r_vi, n_vi;
    logic [IDX_W-1:0]        r_ca, n_ca;
    logic [IDX_W-1:0]        r_cb, n_cb;
    logic [IDX_W-1:0]        r_cc, n_cc;
    logic [VTX_W-1:0]        r_va, n_va;
    logic signed [POS_W:0]   r_e1 [3];
    logic signed [POS_W:0]   n_e1 [3];
    logic signed [POS_W:0]   r_e2 [3];
    logic signed [POS_W:0]   n_e2 [3];
    logic signed [UV_W:0]    r_d1u, n_d1u, r_d1v, n_d1v;
    logic signed [UV_W:0]    r_d2u, n_d2u, r_d2v, n_d2v;
    logic signed [63:0]      r_det, n_det;
    logic signed [63:0]      r_acc, n_acc;
    logic signed [63:0]      r_prod, n_prod;
    logic                    r_nneg, n_nneg;
    logic signed [ACC_W-1:0] r_t [3];
    logic signed [ACC_W-1:0] n_t [3];
    logic [ACC_W-1:0]        r_mg [3];
    logic [ACC_W-1:0]        n_mg [3];
    logic [ACC_W-1:0]        r_m, n_m;
    logic                    r_sg [3];
    logic                    n_sg [3];
    logic [SQRT_W/2-1:0]     r_len, n_len;
    logic [TAN_W-1:0]        r_q [3];
    logic [TAN_W-1:0]        n_q [3];
    logic                    r_zero, n_zero;
    logic [IDX_W-1:0]        r_o_idx, n_o_idx;
    logic [TAN_W-1:0]        r_o_t [3];
    logic [TAN_W-1:0]        n_o_t [3];
    logic                    r_o_zero, n_o_zero;

    // RAM ports
    logic                vs_we;
    logic [AW-1:0]       vs_waddr, vs_raddr;
    logic [VTX_W-1:0]    vs_wdata, vs_rdata;
    logic                ac_we;
    logic [AW-1:0]       ac_waddr, ac_raddr;
    logic [ACCW_W-1:0]   ac_wdata, ac_rdata;

    // shared units
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic [DIV_W-1:0]          div_num, div_den, div_quo;
    logic                      sq_start, sq_done;
    logic [SQRT_W-1:0]         sq_val;
    logic [SQRT_W/2-1:0]       sq_root;

    assign mul_p = mul_a * mul_b;

    mta_ram #(.W(VTX_W), .DEPTH(VERTEX_SLOTS)) u_vstore (
        .i_clk   (i_clk),
        .i_we    (vs_we),
        .i_waddr (vs_waddr),
        .i_wdata (vs_wdata),
        .i_raddr (vs_raddr),
        .o_rdata (vs_rdata)
    );

    mta_ram #(.W(ACCW_W), .DEPTH(VERTEX_SLOTS)) u_accum (
        .i_clk   (i_clk),
        .i_we    (ac_we),
        .i_waddr (ac_waddr),
        .i_wdata (ac_wdata),
        .i_raddr (ac_raddr),
        .o_rdata (ac_rdata)
    );

    mta_div #(.W(DIV_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    mta_sqrt #(.W(SQRT_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // sequencer and datapath next state
    always_comb begin
        logic signed [63:0]      diff;
        logic [DIV_W-1:0]        dmag;
        logic [1:0]              ax;
        logic signed [ACC_W-1:0] tq;
        logic [IDX_W-1:0]        sel_idx;
        logic signed [ACC_W:0]   ssum;
        logic signed [ACC_W-1:0] av;
        logic [ACCW_W-1:0]       wword;
        logic [ACC_W-1:0]        mtmp;
        logic signed [63:0]      sacc;
        logic [TAN_W-1:0]        qv;

        n_state  = r_state;
        n_clr    = r_clr;
        n_ovalid = r_ovalid && i_out_stall;
        n_mstep  = r_mstep;
        n_cj     = r_cj;
        n_vi     = r_vi;
        n_ca     = r_ca;
        n_cb     = r_cb;
        n_cc     = r_cc;
        n_va     = r_va;
        n_e1     = r_e1;
        n_e2     = r_e2;
        n_d1u    = r_d1u;
        n_d1v    = r_d1v;
        n_d2u    = r_d2u;
        n_d2v    = r_d2v;
        n_det    = r_det;
        n_acc    = r_acc;
        n_prod   = r_prod;
        n_nneg   = r_nneg;
        n_t      = r_t;
        n_mg     = r_mg;
        n_m      = r_m;
        n_sg     = r_sg;
        n_len    = r_len;
        n_q      = r_q;
        n_zero   = r_zero;
        n_o_idx  = r_o_idx;
        n_o_t    = r_o_t;
        n_o_zero = r_o_zero;

        vs_we    = 1'b0;
        vs_waddr = to_addr(i_vertex_index);
        vs_wdata = {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v};
        vs_raddr = to_addr(r_ca);
        ac_we    = 1'b0;
        ac_waddr = to_addr(i_vertex_index);
        ac_wdata = '0;
        ac_raddr = to_addr(r_vi);
        mul_a    = '0;
        mul_b    = '0;
        div_start = 1'b0;
        div_num  = '0;
        div_den  = '0;
        sq_start = 1'b0;
        sq_val   = '0;

        diff    = r_acc - r_prod;
        dmag    = diff[63] ? (~diff + 64'sd1) : diff;
        ax      = r_mstep[2:1] - 2'd1;
        tq      = '0;
        ssum    = '0;
        av      = '0;
        wword   = '0;
        mtmp    = '0;
        sacc    = '0;
        qv      = '0;
        unique case (r_cj)
            2'd0:    sel_idx = r_ca;
            2'd1:    sel_idx = r_cb;
            default: sel_idx = r_cc;
        endcase

        unique case (r_state)
            S_CLEAR: begin
                ac_we    = 1'b1;
                ac_waddr = r_clr;
                n_clr    = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_vi = i_vertex_index;
                    n_ca = i_corner_a;
                    n_cb = i_corner_b;
                    n_cc = i_corner_c;
                    unique case (t_op'(i_op))
                        OP_WRITE: begin
                            if (in_range(i_vertex_index)) begin
                                vs_we = 1'b1;
                                ac_we = 1'b1;
                            end
                        end
                        OP_TRI: begin
                            if (in_range(i_corner_a) && in_range(i_corner_b) &&
                                in_range(i_corner_c)) begin
                                n_state = S_VRD_A;
                            end
                        end
                        OP_READ: begin
                            if (in_range(i_vertex_index)) begin
                                n_state = S_RD2;
                            end else begin
                                n_zero  = 1'b1;
                                n_state = S_OUT;
                            end
                        end
                        OP_NOP: begin
                        end
                    endcase
                end
            end
            S_VRD_A: begin
                vs_raddr = to_addr(r_ca);
                n_state  = S_VRD_B;
            end
            S_VRD_B: begin
                vs_raddr = to_addr(r_cb);
                n_va     = vs_rdata;
                n_state  = S_VRD_C;
            end
            S_VRD_C: begin
                // corner b arrives: first edge and UV delta
                vs_raddr = to_addr(r_cc);
                n_e1[0]  = {vs_rdata[143], vs_rdata[143:112]} - {r_va[143], r_va[143:112]};
                n_e1[1]  = {vs_rdata[111], vs_rdata[111:80]}  - {r_va[111], r_va[111:80]};
                n_e1[2]  = {vs_rdata[79], vs_rdata[79:48]}    - {r_va[79], r_va[79:48]};
                n_d1u    = {vs_rdata[47], vs_rdata[47:24]}    - {r_va[47], r_va[47:24]};
                n_d1v    = {vs_rdata[23], vs_rdata[23:0]}     - {r_va[23], r_va[23:0]};
                n_state  = S_VRD_W;
            end
            S_VRD_W: begin
                n_e2[0]  = {vs_rdata[143], vs_rdata[143:112]} - {r_va[143], r_va[143:112]};
                n_e2[1]  = {vs_rdata[111], vs_rdata[111:80]}  - {r_va[111], r_va[111:80]};
                n_e2[2]  = {vs_rdata[79], vs_rdata[79:48]}    - {r_va[79], r_va[79:48]};
                n_d2u    = {vs_rdata[47], vs_rdata[47:24]}    - {r_va[47], r_va[47:24]};
                n_d2v    = {vs_rdata[23], vs_rdata[23:0]}     - {r_va[23], r_va[23:0]};
                n_mstep  = 3'd0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                // steps 0-1 form the determinant, then two per axis
                if (r_mstep == 3'd0) begin
                    mul_a = {{9{r_d1u[UV_W]}}, r_d1u};
                    mul_b = {{9{r_d2v[UV_W]}}, r_d2v};
                end else if (r_mstep == 3'd1) begin
                    mul_a = {{9{r_d2u[UV_W]}}, r_d2u};
                    mul_b = {{9{r_d1v[UV_W]}}, r_d1v};
                end else if (!r_mstep[0]) begin
                    mul_a = {{9{r_d2v[UV_W]}}, r_d2v};
                    mul_b = {r_e1[ax][POS_W], r_e1[ax]};
                end else begin
                    mul_a = {{9{r_d1v[UV_W]}}, r_d1v};
                    mul_b = {r_e2[ax][POS_W], r_e2[ax]};
                end
                n_prod  = mul_p[63:0];
                n_state = S_MACC;
            end
            S_MACC: begin
                if (!r_mstep[0]) begin
                    n_acc   = r_prod;
                    n_mstep = r_mstep + 3'd1;
                    n_state = S_MUL;
                end else if (r_mstep == 3'd1) begin
                    // zero determinant stands in as one LSB
                    n_det   = (diff == 64'sd0) ? 64'sd1 : diff;
                    n_mstep = 3'd2;
                    n_state = S_MUL;
                end else begin
                    div_start = 1'b1;
                    div_num   = dmag;
                    div_den   = r_det[63] ? (~r_det + 64'sd1) : r_det;
                    n_nneg    = diff[63] ^ r_det[63];
                    n_state   = S_DIVW;
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    if (r_nneg) begin
                        tq = (div_quo > LIM_N) ? ACC_MIN : (~div_quo[ACC_W-1:0] + 1'b1);
                    end else begin
                        tq = (div_quo > LIM_P) ? ACC_MAX : div_quo[ACC_W-1:0];
                    end
                    n_t[ax] = tq;
                    if (r_mstep == 3'd7) begin
                        n_cj    = 2'd0;
                        n_state = S_ACC_RD;
                    end else begin
                        n_mstep = r_mstep + 3'd1;
                        n_state = S_MUL;
                    end
                end
            end
            S_ACC_RD: begin
                ac_raddr = to_addr(sel_idx);
                n_state  = S_ACC_WR;
            end
            S_ACC_WR: begin
                // saturating add into one corner; corners run one after another
                for (int k = 0; k < 3; k++) begin
                    av   = ac_rdata[ACCW_W-1-k*ACC_W -: ACC_W];
                    ssum = {av[ACC_W-1], av} + {r_t[k][ACC_W-1], r_t[k]};
                    if (ssum[ACC_W] != ssum[ACC_W-1]) begin
                        wword[ACCW_W-1-k*ACC_W -: ACC_W] = ssum[ACC_W] ? ACC_MIN : ACC_MAX;
                    end else begin
                        wword[ACCW_W-1-k*ACC_W -: ACC_W] = ssum[ACC_W-1:0];
                    end
                end
                ac_we    = 1'b1;
                ac_waddr = to_addr(sel_idx);
                ac_wdata = wword;
                if (r_cj == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_cj    = r_cj + 2'd1;
                    n_state = S_ACC_RD;
                end
            end
            S_RD2: begin
                ac_raddr = to_addr(r_vi);
                n_state  = S_MAG;
            end
            S_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    av      = ac_rdata[ACCW_W-1-k*ACC_W -: ACC_W];
                    n_sg[k] = av[ACC_W-1];
                    n_mg[k] = av[ACC_W-1] ? (~av + 1'b1) : av;
                end
                mtmp = n_mg[0];
                if (n_mg[1] > mtmp) begin
                    mtmp = n_mg[1];
                end
                if (n_mg[2] > mtmp) begin
                    mtmp = n_mg[2];
                end
                n_m = mtmp;
                if (mtmp == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                // one bit a cycle until the largest sits in [2^29, 2^30)
                if (r_m[ACC_W-1:30] != '0) begin
                    for (int k = 0; k < 3; k++) begin
                        n_mg[k] = r_mg[k] >> 1;
                    end
                    n_m = r_m >> 1;
                end else if (!r_m[29]) begin
                    for (int k = 0; k < 3; k++) begin
                        n_mg[k] = r_mg[k] << 1;
                    end
                    n_m = r_m << 1;
                end else begin
                    n_mstep = 3'd0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                mul_a   = {4'd0, r_mg[r_mstep[1:0]][29:0]};
                mul_b   = {4'd0, r_mg[r_mstep[1:0]][29:0]};
                n_prod  = mul_p[63:0];
                n_state = S_SQACC;
            end
            S_SQACC: begin
                sacc  = ((r_mstep == 3'd0) ? 64'sd0 : r_acc) + r_prod;
                n_acc = sacc;
                if (r_mstep == 3'd2) begin
                    sq_start = 1'b1;
                    sq_val   = sacc;
                    n_state  = S_SQRTW;
                end else begin
                    n_mstep = r_mstep + 3'd1;
                    n_state = S_SQ;
                end
            end
            S_SQRTW: begin
                if (sq_done) begin
                    n_len     = sq_root;
                    div_start = 1'b1;
                    div_num   = {r_mg[0], 16'd0};
                    div_den   = {{(DIV_W-SQRT_W/2){1'b0}}, sq_root};
                    n_mstep   = 3'd0;
                    n_state   = S_NDIVW;
                end
            end
            S_NDIVW: begin
                if (div_done) begin
                    qv = div_quo[TAN_W-1:0];
                    n_q[r_mstep[1:0]] = r_sg[r_mstep[1:0]] ? (~qv + 1'b1) : qv;
                    if (r_mstep == 3'd2) begin
                        n_zero  = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_mstep   = r_mstep + 3'd1;
                        div_start = 1'b1;
                        div_num   = {r_mg[r_mstep[1:0] + 2'd1], 16'd0};
                        div_den   = {{(DIV_W-SQRT_W/2){1'b0}}, r_len};
                    end
                end
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_o_idx  = r_vi;
                    n_o_zero = r_zero;
                    for (int k = 0; k < 3; k++) begin
                        n_o_t[k] = r_zero ? '0 : r_q[k];
                    end
                    n_zero  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_mstep  <= '0;
            r_cj     <= '0;
            r_zero   <= 1'b0;
        end else begin
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_mstep  <= n_mstep;
            r_cj     <= n_cj;
            r_zero   <= n_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vi     <= n_vi;
        r_ca     <= n_ca;
        r_cb     <= n_cb;
        r_cc     <= n_cc;
        r_va     <= n_va;
        r_e1     <= n_e1;
        r_e2     <= n_e2;
        r_d1u    <= n_d1u;
        r_d1v    <= n_d1v;
        r_d2u    <= n_d2u;
        r_d2v    <= n_d2v;
        r_det    <= n_det;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_nneg   <= n_nneg;
        r_t      <= n_t;
        r_mg     <= n_mg;
        r_m      <= n_m;
        r_sg     <= n_sg;
        r_len    <= n_len;
        r_q      <= n_q;
        r_o_idx  <= n_o_idx;
        r_o_t    <= n_o_t;
        r_o_zero <= n_o_zero;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_read_index  = r_o_idx;
    assign o_tangent_x   = r_o_t[0];
    assign o_tangent_y   = r_o_t[1];
    assign o_tangent_z   = r_o_t[2];
    assign o_zero_length = r_o_zero;

endmodule
